### rtl/stepgen_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stepgen_pkg;

    // Widths of the step count fields and of the coil pattern on the channels.
    localparam int STEP_W = 16;
    localparam int COIL_W = 4;

    localparam int DEF_COUNT_WIDTH = 16;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_XY_TICK = 2'd1,
        FUNC_Z_TICK  = 2'd2
    } t_func;

    localparam logic [COIL_W-1:0] COILS_OFF = 4'b0000;

    // Control for the z axis unit, already qualified by the pipeline advance.
    typedef struct packed {
        logic load;
        logic tick;
        logic raise;
    } t_z_ctrl;

    // Full-step coil pattern, bits DIR,NDIR,STP,NSTP from msb to lsb.
    function automatic logic [COIL_W-1:0] coil_of(input logic raise, input logic [1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            default: pat = 4'b1001;
        endcase
        // The raising sequence is the lowering one read backwards.
        if (raise) begin
            case (phase)
                2'd0:    pat = 4'b1001;
                2'd1:    pat = 4'b0101;
                2'd2:    pat = 4'b0110;
                default: pat = 4'b1010;
            endcase
        end
        return pat;
    endfunction

endpackage

`default_nettype wire

### rtl/stepgen_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stepgen_cmd_if;
    import stepgen_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [STEP_W-1:0] x_steps;
    logic [STEP_W-1:0] y_steps;
    logic [STEP_W-1:0] z_steps;
    logic              z_raise;

    modport source (output valid, func, x_steps, y_steps, z_steps, z_raise, input ready);
    modport sink   (input valid, func, x_steps, y_steps, z_steps, z_raise, output ready);
endinterface

`default_nettype wire

### rtl/stepgen_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface stepgen_res_if;
    import stepgen_pkg::*;

    logic              valid;
    logic              ready;
    logic              x_step_level;
    logic              y_step_level;
    logic [COIL_W-1:0] z_coils;
    logic              busy_res;
    logic [STEP_W-1:0] x_remaining;
    logic [STEP_W-1:0] y_remaining;
    logic [STEP_W-1:0] z_remaining;

    modport source (output valid, x_step_level, y_step_level, z_coils, busy_res,
                    x_remaining, y_remaining, z_remaining, input ready);
    modport sink   (input valid, x_step_level, y_step_level, z_coils, busy_res,
                    x_remaining, y_remaining, z_remaining, output ready);
endinterface

`default_nettype wire

### rtl/stepgen_zaxis.sv
`timescale 1ns / 1ps
`default_nettype none

module stepgen_zaxis #(
    parameter int COUNT_WIDTH = stepgen_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire stepgen_pkg::t_z_ctrl           i_ctrl,
    input  wire logic [COUNT_WIDTH-1:0]         i_steps,
    output logic [COUNT_WIDTH-1:0]              o_count,
    output logic [COUNT_WIDTH-1:0]              o_count_next,
    output logic [stepgen_pkg::COIL_W-1:0]      o_coils_next
);
    import stepgen_pkg::*;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_raise, n_raise;
    logic [1:0]             r_phase, n_phase;
    logic [COIL_W-1:0]      r_coils, n_coils;

    always_comb begin
        n_count = r_count;
        n_raise = r_raise;
        n_phase = r_phase;
        n_coils = r_coils;
        if (i_ctrl.load) begin
            // A new move keeps the phase so the motor does not jump.
            n_count = i_steps;
            n_raise = i_ctrl.raise;
        end else if (i_ctrl.tick) begin
            if (r_count != '0) begin
                n_coils = coil_of(r_raise, r_phase);
                n_phase = r_phase + 2'd1;
                n_count = r_count - COUNT_WIDTH'(1);
            end else begin
                n_phase = 2'd0;
                n_coils = COILS_OFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_raise <= 1'b0;
            r_phase <= 2'd0;
            r_coils <= COILS_OFF;
        end else begin
            r_count <= n_count;
            r_raise <= n_raise;
            r_phase <= n_phase;
            r_coils <= n_coils;
        end
    end

    assign o_count      = r_count;
    assign o_count_next = n_count;
    assign o_coils_next = n_coils;

    // Coils are either off or drive one of the four full-step patterns.
    a_coil_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coils == 4'b0000 || r_coils == 4'b1010 || r_coils == 4'b0110 ||
        r_coils == 4'b0101 || r_coils == 4'b1001)
        else $error("z coil pattern is not a full-step pattern");

    // With the coils off the sequence always restarts from the first phase.
    a_off_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coils == COILS_OFF |-> r_phase == 2'd0)
        else $error("z phase not at start while coils are off");

    // A tick with steps left moves the count down by one.
    a_z_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.tick && !i_ctrl.load && r_count != '0 |=>
            r_count == $past(r_count) - COUNT_WIDTH'(1))
        else $error("z count did not fall on a z tick");

endmodule

`default_nettype wire

### rtl/three_axis_step_generator.sv
// Three-axis step generator.
// Commands arrive on i_cmd: a load sets the x, y and z step counts and the
// z direction and raises busy; an xy tick toggles the x and y step levels
// while z is idle; a z tick advances the four-phase full-step coil pattern.
// Function code 3 leaves the state alone and simply reports it.
// Every accepted command produces exactly one result transaction on o_res,
// carrying the step levels, the coil pattern, busy and the counts left.
// A command goes into an input register and is applied when its result is
// loaded into the output register, from which the result is offered. One
// command per cycle is sustained; both registers advance together whenever
// the output register is empty or being taken.
// When the receiver stalls, the result and the pending command hold and
// i_cmd.ready falls once both registers are full; nothing is dropped.
// Synchronous reset clears all counts, levels, busy and the coils (off),
// and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_step_generator #(
    parameter int COUNT_WIDTH = stepgen_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    stepgen_cmd_if.sink  i_cmd,
    stepgen_res_if.source o_res
);
    import stepgen_pkg::*;

    // Input register
    logic              r_cmd_valid;
    logic [1:0]        r_cmd_func;
    logic [STEP_W-1:0] r_cmd_x;
    logic [STEP_W-1:0] r_cmd_y;
    logic [STEP_W-1:0] r_cmd_z;
    logic              r_cmd_raise;

    // Axis state
    logic [COUNT_WIDTH-1:0] r_x_count, n_x_count;
    logic [COUNT_WIDTH-1:0] r_y_count, n_y_count;
    logic                   r_x_level, n_x_level;
    logic                   r_y_level, n_y_level;
    logic                   r_busy, n_busy;

    // Output register
    logic              r_res_valid;
    logic              r_res_x_level;
    logic              r_res_y_level;
    logic [COIL_W-1:0] r_res_coils;
    logic              r_res_busy;
    logic [STEP_W-1:0] r_res_x;
    logic [STEP_W-1:0] r_res_y;
    logic [STEP_W-1:0] r_res_z;

    logic                   advance;
    t_func                  func;
    t_z_ctrl                z_ctrl;
    logic [COUNT_WIDTH-1:0] z_count;
    logic [COUNT_WIDTH-1:0] z_count_next;
    logic [COIL_W-1:0]      z_coils_next;

    assign func    = t_func'(r_cmd_func);
    assign advance = r_cmd_valid && (!r_res_valid || o_res.ready);
    assign i_cmd.ready = !r_cmd_valid || advance;

    assign z_ctrl.load  = advance && (func == FUNC_LOAD);
    assign z_ctrl.tick  = advance && (func == FUNC_Z_TICK);
    assign z_ctrl.raise = r_cmd_raise;

    stepgen_zaxis #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_zaxis (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (z_ctrl),
        .i_steps      (COUNT_WIDTH'(r_cmd_z)),
        .o_count      (z_count),
        .o_count_next (z_count_next),
        .o_coils_next (z_coils_next)
    );

    always_comb begin
        n_x_count = r_x_count;
        n_y_count = r_y_count;
        n_x_level = r_x_level;
        n_y_level = r_y_level;
        n_busy    = r_busy;
        case (func)
            FUNC_LOAD: begin
                n_x_count = COUNT_WIDTH'(r_cmd_x);
                n_y_count = COUNT_WIDTH'(r_cmd_y);
                n_busy    = 1'b1;
            end
            FUNC_XY_TICK: begin
                // x and y wait for any z move to finish first.
                if (z_count == '0) begin
                    if (r_x_count != '0) begin
                        n_x_level = !r_x_level;
                        n_x_count = r_x_count - COUNT_WIDTH'(1);
                    end
                    if (r_y_count != '0) begin
                        n_y_level = !r_y_level;
                        n_y_count = r_y_count - COUNT_WIDTH'(1);
                    end
                end
                if (n_x_count == '0 && n_y_count == '0 && z_count == '0) begin
                    n_busy = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_cmd_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_cmd_func  <= i_cmd.func;
            r_cmd_x     <= i_cmd.x_steps;
            r_cmd_y     <= i_cmd.y_steps;
            r_cmd_z     <= i_cmd.z_steps;
            r_cmd_raise <= i_cmd.z_raise;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_count <= '0;
            r_y_count <= '0;
            r_x_level <= 1'b0;
            r_y_level <= 1'b0;
            r_busy    <= 1'b0;
        end else if (advance) begin
            r_x_count <= n_x_count;
            r_y_count <= n_y_count;
            r_x_level <= n_x_level;
            r_y_level <= n_y_level;
            r_busy    <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res_x_level <= n_x_level;
            r_res_y_level <= n_y_level;
            r_res_coils   <= z_coils_next;
            r_res_busy    <= n_busy;
            r_res_x       <= STEP_W'(n_x_count);
            r_res_y       <= STEP_W'(n_y_count);
            r_res_z       <= STEP_W'(z_count_next);
        end
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.x_step_level = r_res_x_level;
    assign o_res.y_step_level = r_res_y_level;
    assign o_res.z_coils      = r_res_coils;
    assign o_res.busy_res     = r_res_busy;
    assign o_res.x_remaining  = r_res_x;
    assign o_res.y_remaining  = r_res_y;
    assign o_res.z_remaining  = r_res_z;

    // A load always leaves a move in progress.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && func == FUNC_LOAD |=> r_busy)
        else $error("busy not set after a load");

    // A pending command is never lost while the output is stalled.
    a_cmd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_valid && !advance |=> r_cmd_valid && $stable(r_cmd_func))
        else $error("pending command lost under stall");

    // x only steps while z is idle.
    a_x_waits_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && func == FUNC_XY_TICK && z_count != '0 |=>
            r_x_count == $past(r_x_count) && r_x_level == $past(r_x_level))
        else $error("x stepped while z was moving");

    // Busy can only be cleared with every axis finished.
    a_busy_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_x_count == '0 && r_y_count == '0 && z_count == '0)
        else $error("busy cleared with steps left");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import stepgen_pkg::*;

    localparam int CW          = DEF_COUNT_WIDTH;
    localparam int WORK_ITEMS  = 1150;
    localparam int CALM_TAIL   = 150;
    localparam int IDLE_LIMIT  = 500;
    localparam int DRAIN_WAIT  = 4;
    localparam int REPORT_MAX  = 10;

    // Function code 3 is not a member of the package enum; it must do nothing.
    localparam logic [1:0] FUNC_NOP = 2'd3;

    localparam logic [COIL_W-1:0] LOWER_COILS [0:3] = '{4'hA, 4'h6, 4'h5, 4'h9};
    localparam logic [COIL_W-1:0] RAISE_COILS [0:3] = '{4'h9, 4'h5, 4'h6, 4'hA};

    typedef struct packed {
        logic [1:0]        func;
        logic [STEP_W-1:0] x;
        logic [STEP_W-1:0] y;
        logic [STEP_W-1:0] z;
        logic              raise;
    } t_cmd;

    typedef struct packed {
        logic              x_lvl;
        logic              y_lvl;
        logic [COIL_W-1:0] coils;
        logic              busy;
        logic [STEP_W-1:0] x_rem;
        logic [STEP_W-1:0] y_rem;
        logic [STEP_W-1:0] z_rem;
    } t_res;

    typedef struct packed {
        t_cmd cmd;
        logic typed;
        t_res res;
    } t_row;

    localparam t_res ALL_CLEAR = '0;

    localparam int N_DIRECTED = 25;
    localparam t_row DIRECTED [0:N_DIRECTED-1] = '{
        // Ticks and the unused code straight after reset report the reset state.
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, ALL_CLEAR},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, ALL_CLEAR},
        '{'{FUNC_NOP,     16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, ALL_CLEAR},
        // A load of all zeros still sets busy, and the next xy tick clears it.
        '{'{FUNC_LOAD,    16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
          '{1'b0, 1'b0, 4'h0, 1'b1, 16'h0000, 16'h0000, 16'h0000}},
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, ALL_CLEAR},
        '{'{FUNC_LOAD,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
          '{1'b0, 1'b0, 4'h0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
        // x and y hold while z still has steps left.
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
          '{1'b0, 1'b0, 4'h0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF}},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
          '{1'b0, 1'b0, 4'h9, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFE}},
        '{'{FUNC_Z_TICK,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}, 1'b0, ALL_CLEAR},
        // Reload in the middle of a move keeps the phase and the step levels.
        '{'{FUNC_LOAD,    16'h0002, 16'h0001, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_XY_TICK, 16'h5A5A, 16'hA5A5, 16'h5A5A, 1'b1}, 1'b0, ALL_CLEAR},
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_LOAD,    16'h0000, 16'h0000, 16'h0003, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_LOAD,    16'h0001, 16'h0000, 16'h0001, 1'b1}, 1'b0, ALL_CLEAR},
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_Z_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_XY_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b0, ALL_CLEAR},
        '{'{FUNC_NOP,     16'h1234, 16'hFEDC, 16'h0F0F, 1'b0}, 1'b0, ALL_CLEAR}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    stepgen_cmd_if cmd_bus ();
    stepgen_res_if res_bus ();

    three_axis_step_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Own copy of the axis state.
    logic [CW-1:0]     x_left, y_left, z_left;
    logic              z_up;
    logic [1:0]        phase;
    logic              x_lvl, y_lvl;
    logic [COIL_W-1:0] coils;
    logic              busy;

    t_res pending_results [$];
    int   failures;
    int   work_sent;
    bit   idling_on;
    bit   quiet;
    int   calm_left;
    int   stall_left = 0;
    int   idle_cycles = 0;

    function automatic t_res apply_command(input t_cmd c);
        t_res r;
        case (c.func)
            FUNC_LOAD: begin
                x_left = CW'(c.x);
                y_left = CW'(c.y);
                z_left = CW'(c.z);
                z_up   = c.raise;
                busy   = 1'b1;
            end
            FUNC_XY_TICK: begin
                if (z_left == '0) begin
                    if (x_left != '0) begin
                        x_lvl  = ~x_lvl;
                        x_left = x_left - 1'b1;
                    end
                    if (y_left != '0) begin
                        y_lvl  = ~y_lvl;
                        y_left = y_left - 1'b1;
                    end
                end
                if (x_left == '0 && y_left == '0 && z_left == '0)
                    busy = 1'b0;
            end
            FUNC_Z_TICK: begin
                if (z_left != '0) begin
                    coils  = z_up ? RAISE_COILS[phase] : LOWER_COILS[phase];
                    phase  = phase + 2'd1;
                    z_left = z_left - 1'b1;
                end else begin
                    phase = 2'd0;
                    coils = COILS_OFF;
                end
            end
            default: ;
        endcase
        r.x_lvl = x_lvl;
        r.y_lvl = y_lvl;
        r.coils = coils;
        r.busy  = busy;
        r.x_rem = STEP_W'(x_left);
        r.y_rem = STEP_W'(y_left);
        r.z_rem = STEP_W'(z_left);
        return r;
    endfunction

    // Offers one command, waits for its transaction and records what it should produce.
    task automatic issue_command(input t_cmd c, input logic typed, input t_res typed_res);
        t_res predicted;
        if (calm_left > 0) begin
            calm_left = calm_left - 1;
        end else if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(20, 60);
        end
        quiet = !idling_on || calm_left > 0;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.func    <= c.func;
        cmd_bus.x_steps <= c.x;
        cmd_bus.y_steps <= c.y;
        cmd_bus.z_steps <= c.z;
        cmd_bus.z_raise <= c.raise;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        predicted = apply_command(c);
        pending_results.push_back(typed ? typed_res : predicted);
        if (c.func != FUNC_NOP)
            work_sent = work_sent + 1;
    endtask

    function automatic t_cmd random_cmd(input logic [1:0] func);
        t_cmd c;
        c.func  = func;
        c.x     = STEP_W'($urandom);
        c.y     = STEP_W'($urandom);
        c.z     = STEP_W'($urandom);
        c.raise = 1'($urandom);
        return c;
    endfunction

    function automatic t_cmd small_load();
        t_cmd c;
        c = random_cmd(FUNC_LOAD);
        c.x = STEP_W'($urandom_range(0, 6));
        c.y = STEP_W'($urandom_range(0, 6));
        c.z = STEP_W'($urandom_range(0, 9));
        return c;
    endfunction

    initial begin
        int   ticks;
        int   sel;
        t_cmd c;

        i_rst_n         = 1'b0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.func    = FUNC_LOAD;
        cmd_bus.x_steps = '0;
        cmd_bus.y_steps = '0;
        cmd_bus.z_steps = '0;
        cmd_bus.z_raise = 1'b0;
        failures        = 0;
        work_sent       = 0;
        idling_on       = 1'b1;
        quiet           = 1'b0;
        calm_left       = 0;
        x_left = '0; y_left = '0; z_left = '0;
        z_up = 1'b0; phase = 2'd0; x_lvl = 1'b0; y_lvl = 1'b0;
        coils = COILS_OFF; busy = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            issue_command(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].res);

        while (work_sent < WORK_ITEMS) begin
            idling_on = (work_sent < WORK_ITEMS - CALM_TAIL);
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
                issue_command(random_cmd(FUNC_NOP), 1'b0, ALL_CLEAR);
            end else if (sel < 12) begin
                // Anything at all, wide counts included.
                issue_command(random_cmd(2'($urandom_range(0, 3))), 1'b0, ALL_CLEAR);
            end else begin
                // A whole move: a small load, then ticks steered towards completion.
                issue_command(small_load(), 1'b0, ALL_CLEAR);
                ticks = $urandom_range(4, 30);
                for (int t = 0; t < ticks; t++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 3) begin
                        c = small_load();
                    end else if (sel < 5) begin
                        c = random_cmd(FUNC_NOP);
                    end else if (z_left != '0) begin
                        c = random_cmd(sel < 75 ? FUNC_Z_TICK : FUNC_XY_TICK);
                    end else begin
                        c = random_cmd(sel < 85 ? FUNC_XY_TICK : FUNC_Z_TICK);
                    end
                    issue_command(c, 1'b0, ALL_CLEAR);
                end
            end
        end
        cmd_bus.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (failures == 0)
            $display("three_axis_step_generator regression: pass");
        else
            $display("three_axis_step_generator regression: fail");
        $finish;
    end

    // Result side: check each transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = '{res_bus.x_step_level, res_bus.y_step_level, res_bus.z_coils,
                    res_bus.busy_res, res_bus.x_remaining, res_bus.y_remaining,
                    res_bus.z_remaining};
            if (pending_results.size() == 0) begin
                failures = failures + 1;
                if (failures <= REPORT_MAX)
                    $display("%0t: result with nothing expected: %h", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (got.x_lvl !== want.x_lvl || got.y_lvl !== want.y_lvl
                        || got.coils !== want.coils || got.busy !== want.busy
                        || got.x_rem !== want.x_rem || got.y_rem !== want.y_rem
                        || got.z_rem !== want.z_rem) begin
                    failures = failures + 1;
                    if (failures <= REPORT_MAX) begin
                        $display("%0t: expected xl=%b yl=%b coils=%h busy=%b x=%h y=%h z=%h",
                                 $realtime, want.x_lvl, want.y_lvl, want.coils, want.busy,
                                 want.x_rem, want.y_rem, want.z_rem);
                        $display("%0t: actual   xl=%b yl=%b coils=%h busy=%b x=%h y=%h z=%h",
                                 $realtime, got.x_lvl, got.y_lvl, got.coils, got.busy,
                                 got.x_rem, got.y_rem, got.z_rem);
                    end
                end
            end
        end

        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            res_bus.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("three_axis_step_generator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

### filelist.f
rtl/stepgen_pkg.sv
rtl/stepgen_cmd_if.sv
rtl/stepgen_res_if.sv
rtl/stepgen_zaxis.sv
rtl/three_axis_step_generator.sv
test/testbench.sv
